@@ sv/object_slot_table_with_box_collision_core_defines.svh @@
// Assertion macros for the object slot table datapath module.
`ifndef OBJECT_SLOT_TABLE_WITH_BOX_COLLISION_CORE_DEFINES_SVH
`define OBJECT_SLOT_TABLE_WITH_BOX_COLLISION_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Checked property, disabled while reset is held.
`define OSTC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("ostc assertion failed");

// Checked property that also holds during reset.
`define OSTC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("ostc assertion failed");

`else

`define OSTC_ASSERT(lbl, clk, rstn, prop)
`define OSTC_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

@@ sv/ostc_pkg.sv @@
// Shared types and constants of the object slot table.
package ostc_pkg;

    localparam int SLOTS   = 8;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int COUNT_W = $clog2(SLOTS + 1);

    // Input word layout.
    localparam int IN_TDATA_W  = 56;
    localparam int IN_TUSER_W  = 2;
    // Output word layout.
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_TUSER_W = 3;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [7:0] RST_ITEM_W  = 8'd8;
    localparam logic [7:0] RST_ITEM_H  = 8'd8;
    localparam logic [3:0] RST_VARIANT = 4'd1;
    localparam logic [7:0] RST_BASE    = 8'd4;

    typedef enum logic [1:0] {
        FN_SPAWN  = 2'd0,
        FN_CHECK  = 2'd1,
        FN_REMOVE = 2'd2
    } t_func;

    typedef enum logic [2:0] {
        ST_SPAWNED = 3'd0,
        ST_FULL    = 3'd1,
        ST_REMOVED = 3'd2,
        ST_IGNORED = 3'd3,
        ST_HIT     = 3'd4,
        ST_NOHIT   = 3'd5
    } t_status;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ITEM_W  = 2'd0,
        CFG_ITEM_H  = 2'd1,
        CFG_VARIANT = 2'd2,
        CFG_BASE    = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic exec;
        logic scan_start;
        logic scan_step;
        logic emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [IN_TUSER_W-1:0] func;
        logic                  scan_end;
        logic                  emit_done;
        logic                  out_free;
    } t_stat;

endpackage

@@ sv/ostc_ctrl.sv @@
// Sequencer that steps each request through decode and, for a check, scan and result emission.
module ostc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  ostc_pkg::t_stat i_stat,
    output ostc_pkg::t_cmd  o_cmd
);

    ostc_pkg::t_state r_state;
    ostc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ostc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ostc_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ostc_pkg::S_DECODE;
                end
            end
            ostc_pkg::S_DECODE: begin
                case (ostc_pkg::t_func'(i_stat.func))
                    ostc_pkg::FN_SPAWN, ostc_pkg::FN_REMOVE: begin
                        if (i_stat.out_free) begin
                            o_cmd.exec = 1'b1;
                            n_state    = ostc_pkg::S_IDLE;
                        end
                    end
                    ostc_pkg::FN_CHECK: begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = ostc_pkg::S_SCAN;
                    end
                    default: begin
                        // The unused code gives no result.
                        n_state = ostc_pkg::S_IDLE;
                    end
                endcase
            end
            ostc_pkg::S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_end) begin
                    n_state = ostc_pkg::S_EMIT;
                end
            end
            ostc_pkg::S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.emit_done) begin
                        n_state = ostc_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = ostc_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ sv/ostc_dp.sv @@
// Slot storage, configuration registers, collision test and output register.
`include "object_slot_table_with_box_collision_core_defines.svh"

module ostc_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [ostc_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [ostc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic [ostc_pkg::IN_TDATA_W-1:0]      i_in_data,
    input  logic [ostc_pkg::IN_TUSER_W-1:0]      i_in_user,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic [ostc_pkg::OUT_TDATA_W-1:0]     o_out_data,
    output logic [ostc_pkg::OUT_TUSER_W-1:0]     o_out_user,
    output logic                                 o_out_last,
    input  ostc_pkg::t_cmd                       i_cmd,
    output ostc_pkg::t_stat                      o_stat
);

    localparam int SLOTS  = ostc_pkg::SLOTS;
    localparam int SLOT_W = ostc_pkg::SLOT_W;
    localparam int CNT_W  = ostc_pkg::COUNT_W;

    // Configuration.
    logic [7:0] r_item_w;
    logic [7:0] r_item_h;
    logic [3:0] r_variant;
    logic [7:0] r_base;

    // Request being worked on.
    logic [ostc_pkg::IN_TUSER_W-1:0] r_func;
    logic [7:0] r_px;
    logic [7:0] r_py;
    logic [3:0] r_kind_in;
    logic [7:0] r_payload;
    logic [7:0] r_bw;
    logic [7:0] r_bh;
    logic [7:0] r_slot_in;

    // Slot table.
    logic [SLOTS-1:0] r_active;
    logic [7:0]       r_sx    [SLOTS];
    logic [7:0]       r_sy    [SLOTS];
    logic [3:0]       r_skind [SLOTS];
    logic [7:0]       r_sval  [SLOTS];
    logic [CNT_W-1:0] r_count;

    // Scan state.
    logic [SLOT_W-1:0] r_scan_idx;
    logic [SLOTS-1:0]  r_hit_mask;

    // Output register.
    logic              r_out_valid;
    ostc_pkg::t_status r_status;
    logic [2:0]        r_slot;
    logic [3:0]        r_hkind;
    logic [7:0]        r_hval;
    logic [7:0]        r_tile;
    logic [3:0]        r_live;
    logic              r_last;

    logic              out_free;
    logic [SLOT_W-1:0] free_idx;
    logic              table_full;
    logic [7:0]        new_tile;
    logic              rm_valid;
    logic [SLOT_W-1:0] rm_idx;
    logic [SLOT_W-1:0] hit_idx;
    logic [SLOTS-1:0]  hit_rest;
    logic              mask_empty;
    logic [SLOT_W-1:0] rd_idx;
    logic [7:0]        rd_x;
    logic [7:0]        rd_y;
    logic [8:0]        box_right;
    logic [8:0]        box_bottom;
    logic [8:0]        obj_right;
    logic [8:0]        obj_bottom;
    logic              slot_hit;
    logic [CNT_W-1:0]  active_ones;
    logic              hit_shown;

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_w  <= ostc_pkg::RST_ITEM_W;
            r_item_h  <= ostc_pkg::RST_ITEM_H;
            r_variant <= ostc_pkg::RST_VARIANT;
            r_base    <= ostc_pkg::RST_BASE;
        end else if (i_cfg_we) begin
            case (ostc_pkg::t_cfg_idx'(i_cfg_addr))
                ostc_pkg::CFG_ITEM_W:  r_item_w  <= i_cfg_data;
                ostc_pkg::CFG_ITEM_H:  r_item_h  <= i_cfg_data;
                ostc_pkg::CFG_VARIANT: r_variant <= i_cfg_data[3:0];
                ostc_pkg::CFG_BASE:    r_base    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_func    <= i_in_user;
            r_px      <= i_in_data[7:0];
            r_py      <= i_in_data[15:8];
            r_kind_in <= i_in_data[19:16];
            r_payload <= i_in_data[27:20];
            r_bw      <= i_in_data[35:28];
            r_bh      <= i_in_data[43:36];
            r_slot_in <= i_in_data[51:44];
        end
    end

    // Lowest free slot for a spawn.
    always_comb begin
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                free_idx = SLOT_W'(i);
            end
        end
    end
    assign table_full = &r_active;
    assign new_tile   = (r_kind_in == r_variant) ? (r_base + {6'd0, r_px[1:0]}) : r_base;

    assign rm_idx   = r_slot_in[SLOT_W-1:0];
    assign rm_valid = (r_slot_in < 8'(SLOTS)) && r_active[rm_idx];

    // Lowest hit still to be reported.
    always_comb begin
        hit_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_hit_mask[i]) begin
                hit_idx = SLOT_W'(i);
            end
        end
    end
    assign mask_empty = (r_hit_mask == '0);
    always_comb begin
        hit_rest          = r_hit_mask;
        hit_rest[hit_idx] = 1'b0;
    end

    // One read address: the scan counter while scanning, the hit while emitting.
    assign rd_idx = i_cmd.scan_step ? r_scan_idx : hit_idx;
    assign rd_x   = r_sx[rd_idx];
    assign rd_y   = r_sy[rd_idx];

    // Sums are nine bits wide so the bounds never wrap.
    assign box_right  = {1'b0, r_px} + {1'b0, r_bw};
    assign box_bottom = {1'b0, r_py} + {1'b0, r_bh};
    assign obj_right  = {1'b0, rd_x} + {1'b0, r_item_w};
    assign obj_bottom = {1'b0, rd_y} + {1'b0, r_item_h};
    assign slot_hit   = r_active[rd_idx]
                        && ({1'b0, r_px} <= obj_right) && ({1'b0, rd_x} <= box_right)
                        && ({1'b0, r_py} <= obj_bottom) && ({1'b0, rd_y} <= box_bottom);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            r_count  <= '0;
        end else if (i_cmd.exec) begin
            if (ostc_pkg::t_func'(r_func) == ostc_pkg::FN_SPAWN) begin
                if (!table_full) begin
                    r_active[free_idx] <= 1'b1;
                    r_count            <= r_count + 1'b1;
                end
            end else if (rm_valid) begin
                r_active[rm_idx] <= 1'b0;
                r_count          <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_skind[i] <= '0;
            end
        end else if (i_cmd.exec && (ostc_pkg::t_func'(r_func) == ostc_pkg::FN_SPAWN)
                     && !table_full) begin
            r_skind[free_idx] <= r_kind_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && (ostc_pkg::t_func'(r_func) == ostc_pkg::FN_SPAWN) && !table_full) begin
            r_sx[free_idx]    <= r_px;
            r_sy[free_idx]    <= r_py;
            r_sval[free_idx]  <= r_payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_scan_idx <= '0;
            r_hit_mask <= '0;
        end else if (i_cmd.scan_step) begin
            r_scan_idx             <= r_scan_idx + 1'b1;
            r_hit_mask[r_scan_idx] <= slot_hit;
        end else if (i_cmd.emit) begin
            r_hit_mask <= hit_rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec || i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_hkind <= '0;
            r_hval  <= '0;
            r_last  <= 1'b1;
            if (ostc_pkg::t_func'(r_func) == ostc_pkg::FN_SPAWN) begin
                if (table_full) begin
                    r_status <= ostc_pkg::ST_FULL;
                    r_slot   <= '0;
                    r_tile   <= '0;
                    r_live   <= 4'(r_count);
                end else begin
                    r_status <= ostc_pkg::ST_SPAWNED;
                    r_slot   <= 3'(free_idx);
                    r_tile   <= new_tile;
                    r_live   <= 4'(r_count + 1'b1);
                end
            end else begin
                r_tile <= '0;
                if (rm_valid) begin
                    r_status <= ostc_pkg::ST_REMOVED;
                    r_slot   <= 3'(rm_idx);
                    r_live   <= 4'(r_count - 1'b1);
                end else begin
                    r_status <= ostc_pkg::ST_IGNORED;
                    r_slot   <= '0;
                    r_live   <= 4'(r_count);
                end
            end
        end else if (i_cmd.emit) begin
            r_tile <= '0;
            r_live <= 4'(r_count);
            if (mask_empty) begin
                r_status <= ostc_pkg::ST_NOHIT;
                r_slot   <= '0;
                r_hkind  <= '0;
                r_hval   <= '0;
                r_last   <= 1'b1;
            end else begin
                r_status <= ostc_pkg::ST_HIT;
                r_slot   <= 3'(hit_idx);
                r_hkind  <= r_skind[hit_idx];
                r_hval   <= r_sval[hit_idx];
                r_last   <= (hit_rest == '0);
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_user  = r_status;
    assign o_out_last  = r_last;
    assign o_out_data  = {5'd0, r_live, r_tile, r_hval, r_hkind, r_slot};

    assign o_stat.func      = r_func;
    assign o_stat.scan_end  = (r_scan_idx == SLOT_W'(SLOTS - 1));
    assign o_stat.emit_done = mask_empty || (hit_rest == '0);
    assign o_stat.out_free  = out_free;

    assign active_ones = CNT_W'($countones(r_active));
    assign hit_shown   = r_out_valid && (r_status == ostc_pkg::ST_HIT);

    // The live count always matches the active marks.
    `OSTC_ASSERT_ALWAYS(a_count_matches, i_clk, !i_rst_n || (r_count == active_ones))
    // Results are only loaded into a free output register.
    `OSTC_ASSERT(a_load_when_free, i_clk, i_rst_n, (i_cmd.exec || i_cmd.emit) |-> out_free)
    // A reported hit names a slot that is still active.
    `OSTC_ASSERT(a_hit_active, i_clk, i_rst_n, hit_shown |-> r_active[r_slot[SLOT_W-1:0]])

endmodule

@@ sv/object_slot_table_with_box_collision_core.sv @@
// Top level of the object slot table with box collision.
//
// A table of eight object slots. A spawn request fills the lowest free slot,
// a remove request clears an active slot, and a collision check tests a box
// against every active slot with inclusive nine-bit bounds, giving one word
// per hit in slot order or a single no-hit word. A spawn or remove is decoded
// and executed once the output register is free, which loads its result word,
// and the block then returns to idle to take the next request. A check scans
// one slot per cycle through the single slot read port, never stalled, and
// then loads its hit words one at a time into the output register, each once
// the register is free, at least one word per check. Results wait in
// an output register; output back-pressure stalls only the step that loads a
// result word. Configuration writes go through i_cfg_we, i_cfg_addr and
// i_cfg_data, take effect at once, and should be made only while the block
// is idle.
module object_slot_table_with_box_collision_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [ostc_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [ostc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // pos_x[7:0], pos_y[15:8], kind[19:16], payload[27:20], box_w[35:28],
    // box_h[43:36], slot_in[51:44], zero fill above.
    input  logic [ostc_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    // func[1:0].
    input  logic [ostc_pkg::IN_TUSER_W-1:0]      i_s_axis_tuser,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // slot_out[2:0], hit_kind[6:3], hit_value[14:7], tile_out[22:15],
    // live_count[26:23], zero fill above.
    output logic [ostc_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    // status[2:0].
    output logic [ostc_pkg::OUT_TUSER_W-1:0]     o_m_axis_tuser,
    output logic                                 o_m_axis_tlast
);

    ostc_pkg::t_cmd  cmd;
    ostc_pkg::t_stat stat;

    ostc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ostc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_s_axis_tdata),
        .i_in_user   (i_s_axis_tuser),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata),
        .o_out_user  (o_m_axis_tuser),
        .o_out_last  (o_m_axis_tlast),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

endmodule

@@ test/tb_object_slot_table_with_box_collision_core.sv @@
// Self-checking testbench for the object slot table with box collision.
`timescale 1ns / 1ps

module tb_object_slot_table_with_box_collision_core;

    localparam logic [1:0] FN_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 24;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic [1:0] func;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic [3:0] kind;
        logic [7:0] payload;
        logic [7:0] box_w;
        logic [7:0] box_h;
        logic [7:0] slot_in;
    } t_request;

    typedef struct {
        ostc_pkg::t_status status;
        logic [2:0]  slot;
        logic [3:0]  kind;
        logic [7:0]  value;
        logic [7:0]  tile;
        logic [3:0]  live;
        logic        last;
    } t_word;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_cfg_we = 1'b0;
    logic [ostc_pkg::CFG_ADDR_W-1:0]  i_cfg_addr = '0;
    logic [ostc_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                             i_s_axis_tvalid = 1'b0;
    logic                             o_s_axis_tready;
    logic [ostc_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic [ostc_pkg::IN_TUSER_W-1:0]  i_s_axis_tuser = '0;
    logic                             o_m_axis_tvalid;
    logic                             i_m_axis_tready = 1'b0;
    logic [ostc_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic [ostc_pkg::OUT_TUSER_W-1:0] o_m_axis_tuser;
    logic                             o_m_axis_tlast;

    object_slot_table_with_box_collision_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #6 i_clk = ~i_clk;

    // Shadow copy of the slot table and its registers.
    logic             slot_on  [ostc_pkg::SLOTS];
    logic [7:0]       slot_px  [ostc_pkg::SLOTS];
    logic [7:0]       slot_py  [ostc_pkg::SLOTS];
    logic [3:0]       slot_kd  [ostc_pkg::SLOTS];
    logic [7:0]       slot_val [ostc_pkg::SLOTS];
    logic [7:0]       slot_tl  [ostc_pkg::SLOTS];
    logic [3:0]       live_slots = '0;
    logic [7:0]       reg_item_w  = ostc_pkg::RST_ITEM_W;
    logic [7:0]       reg_item_h  = ostc_pkg::RST_ITEM_H;
    logic [3:0]       reg_variant = ostc_pkg::RST_VARIANT;
    logic [7:0]       reg_base    = ostc_pkg::RST_BASE;

    t_request request_queue[$];
    t_word    table_words_due[$];
    t_request offered;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic hold_request = 1'b0;
    logic hold_taken = 1'b0;
    int hold_left = 0;
    int cycle_count = 0;

    int n_mismatch = 0;
    int n_spawn = 0;
    int n_check = 0;
    int n_remove = 0;
    int n_full = 0;
    int n_words = 0;
    int n_hits = 0;

    initial begin
        for (int i = 0; i < ostc_pkg::SLOTS; i++) begin
            slot_on[i] = 1'b0;
            slot_px[i] = '0;
            slot_py[i] = '0;
            slot_kd[i] = '0;
            slot_val[i] = '0;
            slot_tl[i] = '0;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (n_mismatch < 40)
            $display("mismatch on %s: got %0d, expected %0d (word %0d)",
                     what, got, want, n_words);
        n_mismatch++;
    endtask

    function automatic t_word make_word(input ostc_pkg::t_status st, input logic [2:0] slot,
                                        input logic [3:0] kind, input logic [7:0] value,
                                        input logic [7:0] tile, input logic last);
        t_word w;
        w.status = st;
        w.slot = slot;
        w.kind = kind;
        w.value = value;
        w.tile = tile;
        w.live = live_slots;
        w.last = last;
        return w;
    endfunction

    // Updates the shadow table for one accepted request and queues the words it yields.
    function automatic void predict_table_words(input t_request r);
        t_word hits[$];
        int free_slot;
        logic [7:0] tile;
        logic [8:0] right, bottom, obj_right, obj_bottom;
        free_slot = -1;
        case (r.func)
            ostc_pkg::FN_SPAWN: begin
                n_spawn++;
                for (int i = ostc_pkg::SLOTS - 1; i >= 0; i--)
                    if (!slot_on[i]) free_slot = i;
                if (free_slot < 0) begin
                    n_full++;
                    table_words_due.push_back(make_word(ostc_pkg::ST_FULL, '0, '0, '0, '0,
                                                        1'b1));
                end else begin
                    tile = reg_base;
                    if (r.kind == reg_variant) tile = reg_base + {6'd0, r.pos_x[1:0]};
                    slot_on[free_slot] = 1'b1;
                    slot_px[free_slot] = r.pos_x;
                    slot_py[free_slot] = r.pos_y;
                    slot_kd[free_slot] = r.kind;
                    slot_val[free_slot] = r.payload;
                    slot_tl[free_slot] = tile;
                    live_slots = live_slots + 4'd1;
                    table_words_due.push_back(make_word(ostc_pkg::ST_SPAWNED, 3'(free_slot),
                                                        '0, '0, tile, 1'b1));
                end
            end
            ostc_pkg::FN_REMOVE: begin
                n_remove++;
                if (r.slot_in < ostc_pkg::SLOTS && slot_on[r.slot_in[2:0]]) begin
                    slot_on[r.slot_in[2:0]] = 1'b0;
                    live_slots = live_slots - 4'd1;
                    table_words_due.push_back(make_word(ostc_pkg::ST_REMOVED, r.slot_in[2:0],
                                                        '0, '0, '0, 1'b1));
                end else begin
                    table_words_due.push_back(make_word(ostc_pkg::ST_IGNORED, '0, '0, '0, '0,
                                                        1'b1));
                end
            end
            ostc_pkg::FN_CHECK: begin
                n_check++;
                // All edges are nine bits wide so that no sum wraps.
                right = {1'b0, r.pos_x} + {1'b0, r.box_w};
                bottom = {1'b0, r.pos_y} + {1'b0, r.box_h};
                for (int i = 0; i < ostc_pkg::SLOTS; i++) begin
                    obj_right = {1'b0, slot_px[i]} + {1'b0, reg_item_w};
                    obj_bottom = {1'b0, slot_py[i]} + {1'b0, reg_item_h};
                    if (slot_on[i] && hits.size() < 8 &&
                        right >= {1'b0, slot_px[i]} && {1'b0, r.pos_x} <= obj_right &&
                        bottom >= {1'b0, slot_py[i]} && {1'b0, r.pos_y} <= obj_bottom)
                        hits.push_back(make_word(ostc_pkg::ST_HIT, 3'(i), slot_kd[i],
                                                 slot_val[i], '0, 1'b0));
                end
                if (hits.size() == 0) begin
                    table_words_due.push_back(make_word(ostc_pkg::ST_NOHIT, '0, '0, '0, '0,
                                                        1'b1));
                end else begin
                    hits[hits.size() - 1].last = 1'b1;
                    n_hits += hits.size();
                    foreach (hits[k]) table_words_due.push_back(hits[k]);
                end
            end
            default: ;
        endcase
    endfunction

    // Sender side.
    always @(posedge i_clk) begin
        logic take_next;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            take_next = !i_s_axis_tvalid;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                predict_table_words(offered);
                take_next = 1'b1;
            end
            if (take_next) begin
                if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered = request_queue.pop_front();
                    i_s_axis_tdata <= {4'd0, offered.slot_in, offered.box_h, offered.box_w,
                                       offered.payload, offered.kind, offered.pos_y,
                                       offered.pos_x};
                    i_s_axis_tuser <= offered.func;
                    i_s_axis_tvalid <= 1'b1;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, taken once on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_request && !hold_taken) begin
            hold_left <= HOLD_CYCLES;
            hold_taken <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver side and word checker.
    always @(posedge i_clk) begin
        t_word want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (table_words_due.size() == 0) begin
                    report_mismatch("unexpected word, status", o_m_axis_tuser, '0);
                end else begin
                    want = table_words_due.pop_front();
                    if (o_m_axis_tuser !== want.status)
                        report_mismatch("status", o_m_axis_tuser, want.status);
                    if (o_m_axis_tdata[2:0] !== want.slot)
                        report_mismatch("slot_out", o_m_axis_tdata[2:0], want.slot);
                    if (o_m_axis_tdata[6:3] !== want.kind)
                        report_mismatch("hit_kind", o_m_axis_tdata[6:3], want.kind);
                    if (o_m_axis_tdata[14:7] !== want.value)
                        report_mismatch("hit_value", o_m_axis_tdata[14:7], want.value);
                    if (o_m_axis_tdata[22:15] !== want.tile)
                        report_mismatch("tile_out", o_m_axis_tdata[22:15], want.tile);
                    if (o_m_axis_tdata[26:23] !== want.live)
                        report_mismatch("live_count", o_m_axis_tdata[26:23], want.live);
                    if (o_m_axis_tlast !== want.last)
                        report_mismatch("last", o_m_axis_tlast, want.last);
                end
                n_words++;
            end
            i_m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still due",
                     cycle_count, table_words_due.size());
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic void queue_request(input logic [1:0] func, input logic [7:0] x,
                                          input logic [7:0] y, input logic [3:0] kind,
                                          input logic [7:0] payload, input logic [7:0] w,
                                          input logic [7:0] h, input logic [7:0] slot);
        t_request r;
        r.func = func;
        r.pos_x = x;
        r.pos_y = y;
        r.kind = kind;
        r.payload = payload;
        r.box_w = w;
        r.box_h = h;
        r.slot_in = slot;
        request_queue.push_back(r);
    endfunction

    function automatic void queue_spawn(input logic [7:0] x, input logic [7:0] y,
                                        input logic [3:0] kind, input logic [7:0] payload);
        queue_request(ostc_pkg::FN_SPAWN, x, y, kind, payload, 8'd0, 8'd0, 8'd0);
    endfunction

    function automatic void queue_check(input logic [7:0] x, input logic [7:0] y,
                                        input logic [7:0] w, input logic [7:0] h);
        queue_request(ostc_pkg::FN_CHECK, x, y, 4'd0, 8'd0, w, h, 8'd0);
    endfunction

    function automatic void queue_remove(input logic [7:0] slot);
        queue_request(ostc_pkg::FN_REMOVE, 8'd0, 8'd0, 4'd0, 8'd0, 8'd0, 8'd0, slot);
    endfunction

    // Mostly spawns, checks and removes around a shared region so that boxes
    // overlap objects; a few unused codes and wide-range values mixed in.
    function automatic void queue_random(input int count);
        int made;
        int sel;
        logic [1:0] func;
        logic [7:0] x, y, w, h, slot;
        logic [3:0] kind;
        made = 0;
        while (made < count) begin
            sel = $urandom_range(99);
            if (sel < 3) func = FN_UNUSED;
            else if (sel < 40) func = ostc_pkg::FN_SPAWN;
            else if (sel < 72) func = ostc_pkg::FN_CHECK;
            else func = ostc_pkg::FN_REMOVE;
            if ($urandom_range(1) == 1) begin
                x = 8'($urandom_range(160, 96));
                y = 8'($urandom_range(160, 96));
            end else begin
                x = 8'($urandom_range(255));
                y = 8'($urandom_range(255));
            end
            kind = ($urandom_range(99) < 40) ? reg_variant : 4'($urandom_range(15));
            w = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(40));
            h = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(40));
            slot = ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(7));
            queue_request(func, x, y, kind, 8'($urandom_range(255)), w, h, slot);
            if (func != FN_UNUSED) made++;
        end
    endfunction

    task automatic write_reg(input ostc_pkg::t_cfg_idx idx, input logic [7:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= value;
        case (idx)
            ostc_pkg::CFG_ITEM_W:  reg_item_w = value;
            ostc_pkg::CFG_ITEM_H:  reg_item_h = value;
            ostc_pkg::CFG_VARIANT: reg_variant = value[3:0];
            ostc_pkg::CFG_BASE:    reg_base = value;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_registers(input logic [7:0] w, input logic [7:0] h,
                                 input logic [3:0] variant, input logic [7:0] base);
        write_reg(ostc_pkg::CFG_ITEM_W, w);
        write_reg(ostc_pkg::CFG_ITEM_H, h);
        write_reg(ostc_pkg::CFG_VARIANT, {4'd0, variant});
        write_reg(ostc_pkg::CFG_BASE, base);
    endtask

    // Waits until every request is taken and every word is back, then lets
    // a request that yields no word finish inside the block.
    task automatic drain_table();
        while (request_queue.size() != 0 || i_s_axis_tvalid || table_words_due.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed part under the reset register values.
        queue_check(8'd0, 8'd0, 8'd255, 8'd255);
        queue_remove(8'd0);
        queue_spawn(8'd0, 8'd0, 4'd0, 8'd0);
        queue_spawn(8'd255, 8'd255, 4'd1, 8'd255);
        queue_spawn(8'd100, 8'd100, 4'd15, 8'hA5);
        queue_spawn(8'd101, 8'd50, 4'd1, 8'h5A);
        queue_spawn(8'd102, 8'd200, 4'd1, 8'd1);
        queue_spawn(8'd30, 8'd30, 4'd7, 8'd7);
        queue_spawn(8'd60, 8'd160, 4'd3, 8'd3);
        queue_spawn(8'd200, 8'd10, 4'd12, 8'd12);
        queue_spawn(8'd5, 8'd5, 4'd2, 8'd99);
        queue_check(8'd0, 8'd0, 8'd255, 8'd255);
        queue_check(8'd108, 8'd108, 8'd0, 8'd0);
        queue_check(8'd109, 8'd100, 8'd0, 8'd0);
        queue_check(8'd255, 8'd255, 8'd0, 8'd0);
        queue_check(8'd92, 8'd92, 8'd0, 8'd0);
        queue_check(8'd92, 8'd92, 8'd8, 8'd8);
        queue_remove(8'd255);
        queue_remove(8'd8);
        queue_remove(8'd3);
        queue_remove(8'd3);
        queue_request(FN_UNUSED, 8'hFF, 8'hFF, 4'hF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        queue_spawn(8'd6, 8'd6, 4'd1, 8'd66);
        queue_check(8'd0, 8'd0, 8'd255, 8'd255);
        drain_table();

        // Zero extents, variant kind zero, tile wrapping past 255.
        set_registers(8'd0, 8'd0, 4'd0, 8'd255);
        send_idle_pct = 79;
        recv_stall_pct = 0;
        queue_random(30);
        drain_table();

        // Full extents make most checks hit many slots.
        set_registers(8'd255, 8'd255, 4'd15, 8'd254);
        send_idle_pct = 0;
        recv_stall_pct = 79;
        queue_random(35);
        drain_table();

        set_registers(8'd20, 8'd12, 4'd5, 8'd128);
        send_idle_pct = 28;
        recv_stall_pct = 28;
        queue_random(40);
        drain_table();

        // Back to the reset values with the receiver held off for a while.
        set_registers(ostc_pkg::RST_ITEM_W, ostc_pkg::RST_ITEM_H, ostc_pkg::RST_VARIANT,
                      ostc_pkg::RST_BASE);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request = 1'b1;
        queue_random(40);
        drain_table();

        $display("Covered %0d spawns (%0d on a full table), %0d box checks, %0d removes,",
                 n_spawn, n_full, n_check, n_remove);
        $display("and %0d result words of which %0d hits, over five register settings.",
                 n_words, n_hits);
        if (n_mismatch == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
